>>> src/upd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// upd_pkg
// Types, character codes and the hex digit helper for the URL percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

  localparam int unsigned UnitW = 16;

  typedef logic [UnitW-1:0] unit_t;

  localparam unit_t ChPlus  = 16'h002B;
  localparam unit_t ChPct   = 16'h0025;
  localparam unit_t ChSpace = 16'h0020;

  // escape state
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,   // no escape pending
    PH_PCT   = 2'd1,   // '%' seen
    PH_DIGIT = 2'd2    // '%' and one hex digit seen
  } phase_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // one decoded result held in the output queue
  typedef struct packed {
    unit_t unit;
    logic  term;
  } slot_t;

  // hex digit value of a code unit, ok low when it is not 0-9, A-F or a-f
  function automatic hex_t hex_of(input unit_t u);
    hex_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (u >= 16'h0030 && u <= 16'h0039) begin
      h.ok  = 1'b1;
      h.val = u[3:0];
    end else if ((u >= 16'h0041 && u <= 16'h0046) ||
                 (u >= 16'h0061 && u <= 16'h0066)) begin
      // 'A'/'a' have low nibble 1, so add 9 for 10..15
      h.ok  = 1'b1;
      h.val = u[3:0] + 4'd9;
    end
    return h;
  endfunction

endpackage
`default_nettype wire

>>> src/upd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// upd_in_if / upd_out_if
// Valid/ready channels of the URL percent decoder: input code units and
// decoded results.
// ----------------------------------------------------------------------------
interface upd_in_if;
  logic                valid;
  logic                ready;
  upd_pkg::unit_t      code_unit;
  logic                end_marker;

  modport source (output valid, output code_unit, output end_marker, input ready);
  modport sink   (input valid, input code_unit, input end_marker, output ready);
endinterface

interface upd_out_if;
  logic                valid;
  logic                ready;
  upd_pkg::unit_t      out_unit;
  logic                is_terminator;
  logic                last_of_run;

  modport source (output valid, output out_unit, output is_terminator,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_unit, input is_terminator,
                  input last_of_run, output ready);
endinterface
`default_nettype wire

>>> src/url_percent_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// url_percent_decoder_unit
// Streaming decoder for form-urlencoded 16-bit code units: '+' to space,
// %hh escapes to one unit, bad escapes passed through, end beat flushes.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                 | handshake
//  in_ch    | in  | code_unit[15:0], end_marker             | valid/ready
//  out_ch   | out | out_unit[15:0], is_terminator, last_of_run | valid/ready
//
//  An input beat is captured in an input register, decoded combinationally
//  and loaded into a queue of up to three results, which drains one result a
//  cycle while out_ch is ready. One-result items then sustain one beat per
//  cycle; an item giving k results holds the single output port for k pops.
//  Synchronous active-low reset clears escape state, queue count and valids;
//  both in_ch.ready and out_ch.valid are held low while reset is asserted.
//  Stalls on out_ch back up through the queue into in_ch.ready.
// ----------------------------------------------------------------------------
module url_percent_decoder_unit (
  input  wire        clk,
  input  wire        rst_n,
  upd_in_if.sink     in_ch,
  upd_out_if.source  out_ch
);

  // input register
  logic            in_v_r;
  upd_pkg::unit_t  in_unit_r;
  logic            in_end_r;

  // escape state
  upd_pkg::phase_t phase_r, phase_nxt;
  upd_pkg::unit_t  held_r, held_nxt;

  // result queue, slot 0 is at the output
  upd_pkg::slot_t  q_r   [3];
  upd_pkg::slot_t  q_nxt [3];
  logic [1:0]      cnt_r, cnt_nxt;

  logic            pop;
  logic            q_free;
  logic            move;

  // decode outputs
  logic [1:0]      pre_n;
  logic            tail_v;
  upd_pkg::slot_t  tail;
  upd_pkg::hex_t   hx_cur;
  upd_pkg::hex_t   hx_held;

  assign pop    = out_ch.valid && out_ch.ready;
  assign q_free = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ch.ready);
  assign move   = in_v_r && q_free;

  assign in_ch.ready = rst_n && (!in_v_r || move);

  // output side
  assign out_ch.valid         = rst_n && (cnt_r != 2'd0);
  assign out_ch.out_unit      = q_r[0].unit;
  assign out_ch.is_terminator = q_r[0].term;
  assign out_ch.last_of_run   = (cnt_r == 2'd1);

  assign hx_cur  = upd_pkg::hex_of(in_unit_r);
  assign hx_held = upd_pkg::hex_of(held_r);

  // decode: a prefix of '%' and held digit, then one optional tail result
  always_comb begin
    pre_n     = 2'd0;
    tail_v    = 1'b0;
    tail.unit = in_unit_r;
    tail.term = 1'b0;
    phase_nxt = upd_pkg::PH_IDLE;
    held_nxt  = held_r;

    if (in_end_r) begin
      case (phase_r)
        upd_pkg::PH_PCT:   pre_n = 2'd1;
        upd_pkg::PH_DIGIT: pre_n = 2'd2;
        default:           pre_n = 2'd0;
      endcase
      tail_v    = 1'b1;
      tail.unit = '0;
      tail.term = 1'b1;
      held_nxt  = '0;
    end else begin
      case (phase_r)
        upd_pkg::PH_PCT: begin
          if (hx_cur.ok) begin
            held_nxt  = in_unit_r;
            phase_nxt = upd_pkg::PH_DIGIT;
          end else begin
            pre_n = 2'd1;
          end
        end
        upd_pkg::PH_DIGIT: begin
          held_nxt = '0;
          if (hx_cur.ok) begin
            tail_v    = 1'b1;
            tail.unit = {8'd0, hx_held.val, hx_cur.val};
          end else begin
            pre_n = 2'd2;
          end
        end
        default: pre_n = 2'd0;
      endcase

      // plain decode of the current unit when the escape did not take it
      if (!(phase_r == upd_pkg::PH_PCT && hx_cur.ok) &&
          !(phase_r == upd_pkg::PH_DIGIT && hx_cur.ok)) begin
        if (in_unit_r == upd_pkg::ChPlus) begin
          tail_v    = 1'b1;
          tail.unit = upd_pkg::ChSpace;
        end else if (in_unit_r == upd_pkg::ChPct) begin
          phase_nxt = upd_pkg::PH_PCT;
        end else begin
          tail_v = 1'b1;
        end
      end
    end
  end

  // queue next value: load on move, else shift on pop
  always_comb begin
    q_nxt[0] = q_r[0];
    q_nxt[1] = q_r[1];
    q_nxt[2] = q_r[2];
    cnt_nxt  = cnt_r;
    if (move) begin
      q_nxt[0] = tail;
      q_nxt[1] = tail;
      q_nxt[2] = tail;
      if (pre_n != 2'd0) begin
        q_nxt[0] = '{unit: upd_pkg::ChPct, term: 1'b0};
      end
      if (pre_n == 2'd2) begin
        q_nxt[1] = '{unit: held_r, term: 1'b0};
      end
      cnt_nxt = pre_n + {1'b0, tail_v};
    end else if (pop) begin
      q_nxt[0] = q_r[1];
      q_nxt[1] = q_r[2];
      cnt_nxt  = cnt_r - 2'd1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      phase_r <= upd_pkg::PH_IDLE;
      held_r  <= '0;
      cnt_r   <= 2'd0;
    end else begin
      if (in_ch.ready) begin
        in_v_r <= in_ch.valid;
      end
      if (move) begin
        phase_r <= phase_nxt;
        held_r  <= held_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_unit_r <= in_ch.code_unit;
      in_end_r  <= in_ch.end_marker;
    end
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
    q_r[2] <= q_nxt[2];
  end

endmodule
`default_nettype wire

>>> bench/tb_url_percent_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_url_percent_decoder_unit
// Self-checking bench for the URL percent decoder. A scoreboard class keeps its
// own escape state and queues the decoded units each accepted input beat should
// give; every output beat is compared against the oldest queued unit. Stimulus
// is a directed run of escape corner cases followed by random encoded strings,
// with random idling on both channels, one long output hold-off and one drain.
// ----------------------------------------------------------------------------
module tb_url_percent_decoder_unit;

  localparam int IdleLimit  = 2000;  // cycles with no beat on either channel
  localparam int HoldCycles = 64;    // long output hold-off
  localparam int RandBeats  = 380;
  localparam int HoldAt     = 120;   // beat index where the long hold-off starts
  localparam int DrainAt    = 240;   // beat index where the sender waits for empty
  localparam int CalmFrom   = 360;   // no idling from this beat on

  // one decoded output beat as predicted
  typedef struct packed {
    upd_pkg::unit_t unit;
    logic           term;
    logic           last;
  } decoded_t;

  // one input beat of the stimulus
  typedef struct packed {
    upd_pkg::unit_t unit;
    logic           end_marker;
  } src_beat_t;

  // --------------------------------------------------------------------------
  // Scoreboard: escape state tracker and queue of awaited decoded units
  // --------------------------------------------------------------------------
  class decode_scoreboard;
    decoded_t        decoded_q[$];
    upd_pkg::phase_t phase;
    upd_pkg::unit_t  held;
    int              errors;

    function new();
      phase  = upd_pkg::PH_IDLE;
      held   = '0;
      errors = 0;
    endfunction

    // value of a hex digit unit, -1 when not 0-9, A-F or a-f
    function int digit_value(upd_pkg::unit_t u);
      if (u >= 16'h0030 && u <= 16'h0039) return int'(u) - 'h30;
      if (u >= 16'h0041 && u <= 16'h0046) return int'(u) - 'h41 + 10;
      if (u >= 16'h0061 && u <= 16'h0066) return int'(u) - 'h61 + 10;
      return -1;
    endfunction

    function void push(upd_pkg::unit_t u, logic term);
      decoded_t d;
      d.unit = u;
      d.term = term;
      d.last = 1'b0;
      decoded_q.push_back(d);
    endfunction

    // unit with no escape pending
    function void decode_plain(upd_pkg::unit_t u);
      if (u == upd_pkg::ChPlus) push(upd_pkg::ChSpace, 1'b0);
      else if (u == upd_pkg::ChPct) phase = upd_pkg::PH_PCT;
      else push(u, 1'b0);
    endfunction

    // accepted input beat: queue the units it decodes to
    function void note_beat(upd_pkg::unit_t u, logic end_marker);
      int first;
      int hi;
      int lo;
      first = decoded_q.size();
      if (end_marker) begin
        // flush a pending '%' or '%digit' ahead of the terminator
        if (phase == upd_pkg::PH_PCT) begin
          push(upd_pkg::ChPct, 1'b0);
        end else if (phase == upd_pkg::PH_DIGIT) begin
          push(upd_pkg::ChPct, 1'b0);
          push(held, 1'b0);
        end
        phase = upd_pkg::PH_IDLE;
        held  = '0;
        push('0, 1'b1);
      end else begin
        case (phase)
          upd_pkg::PH_PCT: begin
            if (digit_value(u) >= 0) begin
              held  = u;
              phase = upd_pkg::PH_DIGIT;
            end else begin
              phase = upd_pkg::PH_IDLE;
              push(upd_pkg::ChPct, 1'b0);
              decode_plain(u);
            end
          end
          upd_pkg::PH_DIGIT: begin
            lo    = digit_value(u);
            hi    = digit_value(held);
            phase = upd_pkg::PH_IDLE;
            if (lo >= 0) begin
              push(upd_pkg::unit_t'(hi * 16 + lo), 1'b0);
            end else begin
              push(upd_pkg::ChPct, 1'b0);
              push(held, 1'b0);
              decode_plain(u);
            end
            held = '0;
          end
          default: begin
            phase = upd_pkg::PH_IDLE;
            decode_plain(u);
          end
        endcase
      end
      if (decoded_q.size() > first) decoded_q[decoded_q.size()-1].last = 1'b1;
    endfunction

    task report(string msg);
      $display("%0t: decoder mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // accepted output beat against the oldest awaited unit
    task check_result(upd_pkg::unit_t u, logic term, logic last);
      decoded_t d;
      if (decoded_q.size() == 0) begin
        report($sformatf("unexpected beat unit=%h term=%b last=%b", u, term, last));
        return;
      end
      d = decoded_q.pop_front();
      if (u !== d.unit)
        report($sformatf("out_unit %h, predicted %h", u, d.unit));
      if (term !== d.term)
        report($sformatf("is_terminator %b, predicted %b (unit %h)", term, d.term, d.unit));
      if (last !== d.last)
        report($sformatf("last_of_run %b, predicted %b (unit %h)", last, d.last, d.unit));
    endtask

    function int pending();
      return decoded_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  always #10 clk = ~clk;

  upd_in_if  in_ch ();
  upd_out_if out_ch ();

  url_percent_decoder_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  decode_scoreboard sb = new();
  src_beat_t        beats[$];

  int tx_gap_pct;      // chance of an idle burst before an input beat
  int rx_stall_pct;    // chance of a stall burst on the output
  bit long_hold_req;
  int idle_cycles = 0;

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function upd_pkg::unit_t hex_char(int v);
    if (v < 10) return upd_pkg::unit_t'(16'h0030 + v);
    if ($urandom_range(0, 1)) return upd_pkg::unit_t'(16'h0041 + v - 10);
    return upd_pkg::unit_t'(16'h0061 + v - 10);
  endfunction

  // units around the hex ranges, plus the special characters
  function upd_pkg::unit_t noise_unit();
    case ($urandom_range(0, 9))
      0: return upd_pkg::ChPct;
      1: return upd_pkg::ChPlus;
      2: return 16'h002F;   // '/' below '0'
      3: return 16'h003A;   // ':' above '9'
      4: return 16'h0040;   // '@' below 'A'
      5: return 16'h0047;   // 'G' above 'F'
      6: return 16'h0060;   // '`' below 'a'
      7: return 16'h0067;   // 'g' above 'f'
      8: return 16'h0000;
      default: return upd_pkg::unit_t'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  function void add_unit(upd_pkg::unit_t u);
    src_beat_t b;
    b.unit       = u;
    b.end_marker = 1'b0;
    beats.push_back(b);
  endfunction

  // end beat, carrying the given (ignored) code unit
  function void add_end(upd_pkg::unit_t u);
    src_beat_t b;
    b.unit       = u;
    b.end_marker = 1'b1;
    beats.push_back(b);
  endfunction

  function void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_unit(upd_pkg::unit_t'(s[i]));
  endfunction

  // one random encoded string, mostly well formed, ending in an end beat
  function void add_random_string();
    int tokens;
    tokens = $urandom_range(0, 12);
    for (int i = 0; i < tokens; i++) begin
      case ($urandom_range(0, 9))
        0, 1: add_unit(upd_pkg::unit_t'($urandom_range(0, 16'hFFFF)));
        2:    add_unit(upd_pkg::unit_t'($urandom_range(16'h0020, 16'h007E)));
        3:    add_unit(upd_pkg::ChPlus);
        4, 5, 6: begin
          add_unit(upd_pkg::ChPct);
          add_unit(hex_char($urandom_range(0, 15)));
          add_unit(hex_char($urandom_range(0, 15)));
        end
        7: begin
          add_unit(upd_pkg::ChPct);
          add_unit(noise_unit());
        end
        8: begin
          add_unit(upd_pkg::ChPct);
          add_unit(hex_char($urandom_range(0, 15)));
          add_unit(noise_unit());
        end
        default: add_unit($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
      endcase
    end
    // now and then leave an escape open at the end
    case ($urandom_range(0, 7))
      0: add_unit(upd_pkg::ChPct);
      1: begin
        add_unit(upd_pkg::ChPct);
        add_unit(hex_char($urandom_range(0, 15)));
      end
      default: ;
    endcase
    add_end(upd_pkg::unit_t'($urandom_range(0, 16'hFFFF)));
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: offer one beat and wait for it to be taken
  // --------------------------------------------------------------------------
  task send_beat(src_beat_t b);
    if (tx_gap_pct > 0 && $urandom_range(1, 100) <= tx_gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.code_unit  <= b.unit;
    in_ch.end_marker <= b.end_marker;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_beat(b.unit, b.end_marker);
  endtask

  task wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Output side: check accepted beats, stall in random bursts
  // --------------------------------------------------------------------------
  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.out_unit, out_ch.is_terminator, out_ch.last_of_run);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = HoldCycles - 1;
        out_ch.ready <= 1'b0;
      end else if (rx_stall_pct > 0 && $urandom_range(1, 100) <= rx_stall_pct) begin
        stall_left    = $urandom_range(1, 10) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long with no beat on either channel
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("tb_url_percent_decoder_unit: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int directed_n;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.code_unit  = '0;
    in_ch.end_marker = 1'b0;
    long_hold_req    = 1'b0;
    tx_gap_pct       = 20;
    rx_stall_pct     = 20;

    // directed: plus, extreme units, escapes of both cases, %00,
    // bad first and second digits, '%%', ends with an escape open
    add_unit(upd_pkg::ChPlus);
    add_unit(16'hFFFF);
    add_unit(16'h0000);
    add_text("%Af%00%g%9+%%a9%/%F:");
    add_text("%");
    add_end(16'hFFFF);
    add_text("%7");
    add_end(16'h0000);
    add_end(16'h5A5A);
    directed_n = beats.size();

    while (beats.size() < directed_n + RandBeats) add_random_string();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (beats[i]) begin
      if (i == HoldAt) long_hold_req = 1'b1;
      if (i == DrainAt) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait_drained();
      end
      // fresh traffic mix at each string boundary, none in the closing stretch
      if (i >= CalmFrom) begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end else if (i > 0 && beats[i-1].end_marker) begin
        tx_gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
        rx_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
      end
      send_beat(beats[i]);
    end
    in_ch.valid <= 1'b0;

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_url_percent_decoder_unit: clean");
    end else begin
      $display("tb_url_percent_decoder_unit: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
src/upd_pkg.sv
src/upd_if.sv
src/url_percent_decoder_unit.sv
bench/tb_url_percent_decoder_unit.sv
